// ----- rtl/obstacle_speed_limiter_defines.svh -----
// Assertion macros for the obstacle speed limiter.
// Depends on nothing; the including module must provide clk and rst.
`ifndef OBSTACLE_SPEED_LIMITER_DEFINES_SVH
`define OBSTACLE_SPEED_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define OSL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/osl_pkg.sv -----
// Shared constants, types and tables of the obstacle speed limiter.
// Depends on nothing.
package osl_pkg;

  localparam int FRAC_BITS       = 12;
  localparam int ANG_FRAC        = 30;
  localparam int CORDIC_PRESHIFT = 16;
  localparam int ATAN_DEPTH      = 28;
  localparam int CORDIC_ITER     = (FRAC_BITS + 4 > ATAN_DEPTH) ? ATAN_DEPTH : FRAC_BITS + 4;
  localparam int ITW             = $clog2(ATAN_DEPTH);

  localparam int CW    = 44;
  localparam int ANGW  = 40;
  localparam int DVDW  = 49;
  localparam int DVSW  = 33;
  localparam int DCNTW = $clog2(DVDW + 1);
  localparam int GAPW  = 25;
  localparam int DISTW = 25;
  localparam int SQW   = 50;
  localparam int NDW   = 34;
  localparam int MULAW = 33;
  localparam int MULBW = 25;
  localparam int PRODW = 49;
  localparam int CFG_IDXW = 3;
  localparam int CFG_DW   = 24;

  localparam logic [ANGW-1:0] PI_Q30 = 40'd3373259426;
  localparam logic [SQW-1:0]  SQ_B0  = SQW'(1) << (2 * (DISTW - 1));

  localparam logic [1:0] FUNC_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_OBST  = 2'd1;
  localparam logic [1:0] FUNC_SCORE = 2'd2;

  localparam logic [CFG_IDXW-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDXW-1:0] CFG_BOX_MAX_X = 3'd1;
  localparam logic [CFG_IDXW-1:0] CFG_BOX_MIN_Y = 3'd2;
  localparam logic [CFG_IDXW-1:0] CFG_BOX_MAX_Y = 3'd3;
  localparam logic [CFG_IDXW-1:0] CFG_MIN_SPEED = 3'd4;
  localparam logic [CFG_IDXW-1:0] CFG_MAX_SPEED = 3'd5;
  localparam logic [CFG_IDXW-1:0] CFG_DECEL     = 3'd6;
  localparam logic [CFG_IDXW-1:0] CFG_HALF_ANG  = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SD_MUL, ST_SD_START, ST_SD_WAIT, ST_CORDIC, ST_BEARING,
    ST_SQ_X, ST_SQ_Y, ST_SQRT, ST_INTERP, ST_IMUL, ST_IDIV_START,
    ST_IDIV_WAIT, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  function automatic logic [ANGW-1:0] atan_lut(input logic [ITW-1:0] idx);
    logic [ANGW-1:0] v;
    case (idx)
      5'd0:  v = 40'd843314857;
      5'd1:  v = 40'd497837829;
      5'd2:  v = 40'd263043837;
      5'd3:  v = 40'd133525159;
      5'd4:  v = 40'd67021687;
      5'd5:  v = 40'd33543516;
      5'd6:  v = 40'd16775851;
      5'd7:  v = 40'd8388437;
      5'd8:  v = 40'd4194283;
      5'd9:  v = 40'd2097149;
      5'd10: v = 40'd1048576;
      5'd11: v = 40'd524288;
      5'd12: v = 40'd262144;
      5'd13: v = 40'd131072;
      5'd14: v = 40'd65536;
      5'd15: v = 40'd32768;
      5'd16: v = 40'd16384;
      5'd17: v = 40'd8192;
      5'd18: v = 40'd4096;
      5'd19: v = 40'd2048;
      5'd20: v = 40'd1024;
      5'd21: v = 40'd512;
      5'd22: v = 40'd256;
      5'd23: v = 40'd128;
      5'd24: v = 40'd64;
      5'd25: v = 40'd32;
      5'd26: v = 40'd16;
      5'd27: v = 40'd8;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/osl_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on osl_pkg.
module osl_div import osl_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  div_ctl_t        ctl,
  input  logic [DVDW-1:0] dividend,
  input  logic [DVSW-1:0] divisor,
  output div_sts_t        sts,
  output logic [DVDW-1:0] quotient
);

  logic [DVDW-1:0]  dvd;
  logic [DVSW-1:0]  dvs;
  logic [DVSW-1:0]  rem;
  logic [DCNTW-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DVSW:0]    trial;
  logic             fits;

  always_comb begin
    trial = {rem, dvd[DVDW-1]};
    fits  = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= DCNTW'(DVDW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= fits ? DVSW'(trial - {1'b0, dvs}) : trial[DVSW-1:0];
      dvd <= {dvd[DVDW-2:0], fits};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = dvd;

endmodule

// ----- rtl/obstacle_speed_limiter.sv -----
// Top level of the obstacle speed limiter: configuration registers, sequencer,
// CORDIC, square root and interpolation datapath.
// Depends on osl_pkg, osl_div and obstacle_speed_limiter_defines.svh.
//
// Usage: input words arrive on in_valid/in_ready with func selecting begin
// frame, obstruction or score trajectory. Every input word yields exactly one
// output word on out_valid/out_ready. Configuration writes use cfg_valid and
// cfg_ready (always ready) with cfg_index and cfg_data.
// Sequence: a score word, an unused func or an obstruction dropped by its type
// or cleared flag goes straight to the output state. An obstruction dropped by
// the bearing first runs the CORDIC loop. A begin frame runs two multiplies and
// two divisions, for the near and the far stop distance. A considered obstruction
// runs the CORDIC loop, the square root and, when interpolated, one multiply and
// one division on the shared divider.
// The sequencer takes no new input word until the last one has reached the
// output state.
// A finished word waits in the output register while the next input word is
// taken; if the receiver stalls with a word still held, the sequencer waits
// before writing the next one. Reset returns the configuration, state, stop
// distances and kept speed limit to reset values and empties the output register.
`include "obstacle_speed_limiter_defines.svh"

module obstacle_speed_limiter import osl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic signed [23:0]  obs_x,
  input  logic signed [23:0]  obs_y,
  input  logic                is_dynamic,
  input  logic                is_cleared,
  input  logic signed [16:0]  traj_velocity,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [15:0]         speed_limit_out,
  output logic                considered,
  output logic                reject,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CFG_IDXW-1:0] cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  logic signed [23:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic [15:0]        min_speed, max_speed, decel_rate;
  logic [13:0]        bearing_half_angle;
  logic [15:0]        speed_limit;
  logic [31:0]        near_stop_dist, far_stop_dist;

  state_t state, state_next;

  logic signed [23:0]   px, py;
  logic                 cons_r, rej_r, sd_far;
  logic signed [CW-1:0] cx, cy;
  logic signed [ANGW-1:0] cz;
  logic [ITW-1:0]       iter;
  logic [PRODW-1:0]     prod;
  logic [SQW-1:0]       sq_acc, sq_v, sq_r, sq_b;
  logic signed [NDW-1:0] num_r, den_r;

  logic [MULAW-1:0]          mul_a;
  logic [MULBW-1:0]          mul_b;
  logic [MULAW+MULBW-1:0]    mul_p;
  div_ctl_t                  div_ctl;
  div_sts_t                  div_sts;
  logic [DVDW-1:0]           div_dvd;
  logic [DVSW-1:0]           div_dvs;
  logic [DVDW-1:0]           div_q;

  logic [16:0]          decel_eff;
  logic [15:0]          sd_v;
  logic [17:0]          vel_abs;
  logic [GAPW-1:0]      gap_x, gap_y;
  logic [SQW-1:0]       sq_rb;
  logic signed [ANGW-1:0] th_base, th;
  logic [ANGW-1:0]      half_q30;
  logic signed [NDW-1:0] n_raw, d_raw, n_fl, d_fl;
  logic                 interp_early;
  logic [15:0]          interp_s;
  logic signed [16:0]   delta;
  logic [15:0]          mag;
  logic [15:0]          div_s;
  logic signed [CW-1:0] cx_sh, cy_sh;

  function automatic logic [GAPW-1:0] axis_gap(input logic signed [23:0] p,
                                               input logic signed [23:0] lo,
                                               input logic signed [23:0] hi);
    logic signed [GAPW:0] d;
    d = '0;
    if (p < lo) begin
      d = $signed({{2{lo[23]}}, lo}) - $signed({{2{p[23]}}, p});
    end else if (p > hi) begin
      d = $signed({{2{p[23]}}, p}) - $signed({{2{hi[23]}}, hi});
    end
    return d[GAPW-1:0];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x          <= -24'sd2867;
      box_max_x          <= 24'sd2867;
      box_min_y          <= -24'sd2867;
      box_max_y          <= 24'sd2867;
      min_speed          <= 16'd0;
      max_speed          <= 16'd4096;
      decel_rate         <= 16'd2867;
      bearing_half_angle <= 14'd6554;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BOX_MIN_X: box_min_x          <= $signed(cfg_data);
        CFG_BOX_MAX_X: box_max_x          <= $signed(cfg_data);
        CFG_BOX_MIN_Y: box_min_y          <= $signed(cfg_data);
        CFG_BOX_MAX_Y: box_max_y          <= $signed(cfg_data);
        CFG_MIN_SPEED: min_speed          <= cfg_data[15:0];
        CFG_MAX_SPEED: max_speed          <= cfg_data[15:0];
        CFG_DECEL:     decel_rate         <= cfg_data[15:0];
        CFG_HALF_ANG:  bearing_half_angle <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    decel_eff = (decel_rate == 16'd0) ? 17'd1 : {1'b0, decel_rate};
    sd_v      = sd_far ? max_speed : min_speed;
    vel_abs   = traj_velocity[16] ? 18'(-$signed({traj_velocity[16], traj_velocity}))
                                  : {1'b0, traj_velocity};
    gap_x     = axis_gap(px, box_min_x, box_max_x);
    gap_y     = axis_gap(py, box_min_y, box_max_y);
    sq_rb     = sq_r + sq_b;
    cx_sh     = cx >>> iter;
    cy_sh     = cy >>> iter;
    th_base   = (py == 24'sd0) ? '0 : (cz < 0 ? '0 : cz);
    th        = px[23] ? $signed(PI_Q30) - th_base : th_base;
    half_q30  = ANGW'(bearing_half_angle) << (ANG_FRAC - FRAC_BITS);
    delta     = $signed({1'b0, max_speed}) - $signed({1'b0, min_speed});
    mag       = delta[16] ? 16'(-delta) : delta[15:0];
    n_raw     = $signed(NDW'(sq_r[DISTW-1:0])) - $signed(NDW'(near_stop_dist));
    d_raw     = $signed(NDW'(far_stop_dist)) - $signed(NDW'(near_stop_dist));
    n_fl      = d_raw[NDW-1] ? -n_raw : n_raw;
    d_fl      = d_raw[NDW-1] ? -d_raw : d_raw;
    interp_early = 1'b1;
    interp_s     = max_speed;
    if (d_raw == '0) begin
      interp_s = (n_raw >= 0) ? max_speed : min_speed;
    end else if (n_fl <= 0) begin
      interp_s = min_speed;
    end else if (n_fl >= d_fl) begin
      interp_s = max_speed;
    end else begin
      interp_early = 1'b0;
    end
    div_s = delta[16] ? 16'(min_speed - div_q[15:0]) : 16'(min_speed + div_q[15:0]);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_BEGIN: state_next = ST_SD_MUL;
            FUNC_OBST:  state_next = (is_dynamic && !is_cleared) ? ST_CORDIC : ST_OUT;
            default:    state_next = ST_OUT;
          endcase
        end
      end
      ST_SD_MUL:     state_next = ST_SD_START;
      ST_SD_START:   state_next = ST_SD_WAIT;
      ST_SD_WAIT:    if (div_sts.done) state_next = sd_far ? ST_OUT : ST_SD_MUL;
      ST_CORDIC:     if (iter == ITW'(CORDIC_ITER - 1)) state_next = ST_BEARING;
      ST_BEARING:    state_next = ($unsigned(th) <= half_q30) ? ST_SQ_X : ST_OUT;
      ST_SQ_X:       state_next = ST_SQ_Y;
      ST_SQ_Y:       state_next = ST_SQRT;
      ST_SQRT:       if (sq_b == SQW'(1)) state_next = ST_INTERP;
      ST_INTERP:     state_next = interp_early ? ST_OUT : ST_IMUL;
      ST_IMUL:       state_next = ST_IDIV_START;
      ST_IDIV_START: state_next = ST_IDIV_WAIT;
      ST_IDIV_WAIT:  if (div_sts.done) state_next = ST_OUT;
      ST_OUT:        if (!out_valid || out_ready) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    div_ctl.start = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    div_dvd       = prod + DVDW'(decel_eff);
    div_dvs       = DVSW'({decel_eff, 1'b0});
    case (state)
      ST_IDLE:     in_ready = 1'b1;
      ST_SD_MUL: begin
        mul_a = MULAW'(sd_v);
        mul_b = MULBW'(sd_v);
      end
      ST_SD_START: div_ctl.start = 1'b1;
      ST_SQ_X: begin
        mul_a = MULAW'(gap_x);
        mul_b = gap_x;
      end
      ST_SQ_Y: begin
        mul_a = MULAW'(gap_y);
        mul_b = gap_y;
      end
      ST_IMUL: begin
        mul_a = num_r[MULAW-1:0];
        mul_b = MULBW'(mag);
      end
      ST_IDIV_START: begin
        div_ctl.start = 1'b1;
        div_dvd       = prod + DVDW'(den_r >>> 1);
        div_dvs       = den_r[DVSW-1:0];
      end
      ST_IDIV_WAIT: begin
        div_dvd = prod + DVDW'(den_r >>> 1);
        div_dvs = den_r[DVSW-1:0];
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  osl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      speed_limit    <= 16'd4096;
      near_stop_dist <= 32'd0;
      far_stop_dist  <= 32'd2926;
    end else begin
      state <= state_next;
      if (state == ST_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_SD_WAIT && div_sts.done) begin
        if (sd_far) begin
          far_stop_dist <= div_q[31:0];
          speed_limit   <= max_speed;
        end else begin
          near_stop_dist <= div_q[31:0];
        end
      end
      if (state == ST_INTERP && interp_early && interp_s < speed_limit) begin
        speed_limit <= interp_s;
      end
      if (state == ST_IDIV_WAIT && div_sts.done && div_s < speed_limit) begin
        speed_limit <= div_s;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px     <= obs_x;
        py     <= obs_y;
        cons_r <= 1'b0;
        rej_r  <= (func == FUNC_SCORE) && (vel_abs > 18'(speed_limit));
        sd_far <= 1'b0;
        iter   <= '0;
        cz     <= '0;
        cx     <= CW'(obs_x[23] ? 25'(-$signed({obs_x[23], obs_x})) : {1'b0, obs_x})
                  << CORDIC_PRESHIFT;
        cy     <= CW'(obs_y[23] ? 25'(-$signed({obs_y[23], obs_y})) : {1'b0, obs_y})
                  << CORDIC_PRESHIFT;
      end
      ST_SD_MUL:  prod <= mul_p[PRODW-1:0];
      ST_SD_WAIT: if (div_sts.done) sd_far <= 1'b1;
      ST_CORDIC: begin
        iter <= iter + 1'b1;
        if (cy > 0) begin
          cx <= cx + cy_sh;
          cy <= cy - cx_sh;
          cz <= cz + $signed(atan_lut(iter));
        end else begin
          cx <= cx - cy_sh;
          cy <= cy + cx_sh;
          cz <= cz - $signed(atan_lut(iter));
        end
      end
      ST_BEARING: begin
        cons_r <= $unsigned(th) <= half_q30;
        sq_r   <= '0;
        sq_b   <= SQ_B0;
      end
      ST_SQ_X: sq_acc <= SQW'(mul_p);
      ST_SQ_Y: sq_v   <= sq_acc + SQW'(mul_p);
      ST_SQRT: begin
        if (sq_v >= sq_rb) begin
          sq_v <= sq_v - sq_rb;
          sq_r <= (sq_r >> 1) + sq_b;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_b <= sq_b >> 2;
      end
      ST_INTERP: begin
        num_r <= n_fl;
        den_r <= d_fl;
      end
      ST_IMUL: prod <= mul_p[PRODW-1:0];
      ST_OUT: begin
        if (!out_valid || out_ready) begin
          speed_limit_out <= speed_limit;
          considered      <= cons_r;
          reject          <= rej_r;
        end
      end
      default: ;
    endcase
  end

  `OSL_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `OSL_ASSERT_NOW(a_div_done_expected, div_sts.done, state == ST_SD_WAIT || state == ST_IDIV_WAIT)
  `OSL_ASSERT_NOW(a_flags_exclusive, out_valid, !(considered && reject))

endmodule

// ----- tb/obstacle_speed_limiter_test.sv -----
// Self-checking testbench of the obstacle speed limiter: directed and random words
// are checked against a fixed-point predictor kept in step with the configuration.
// Depends on osl_pkg and the obstacle_speed_limiter RTL.
module obstacle_speed_limiter_test;
  import osl_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    logic [1:0]         func;
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic               dyn;
    logic               clr;
    logic signed [16:0] vel;
  } item_t;

  typedef struct {
    logic [15:0] limit;
    logic        cons;
    logic        rej;
  } verdict_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic [1:0] func = '0;
  logic signed [23:0] obs_x = '0;
  logic signed [23:0] obs_y = '0;
  logic is_dynamic = 0;
  logic is_cleared = 0;
  logic signed [16:0] traj_velocity = '0;
  logic out_valid;
  logic out_ready = 0;
  logic [15:0] speed_limit_out;
  logic considered;
  logic reject;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDXW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  obstacle_speed_limiter dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  item_t pending[$];
  verdict_t awaited[$];
  item_t cur;
  int fails = 0;
  bit quiet = 0;
  int in_gap = 0;
  int out_gap = 0;
  int stalled = 0;

  // Predictor state.
  longint p_min_x, p_max_x, p_min_y, p_max_y;
  longint p_vmin, p_vmax, p_decel, p_half;
  longint p_limit, p_near, p_far;

  longint atan_tab[28] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8};

  function automatic longint brake_dist(longint v);
    longint a;
    longint q;
    a = (p_decel == 0) ? 1 : p_decel;
    q = (v * v + a) / (2 * a);
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic longint bearing_q30(longint x, longint y);
    longint ax, ay, cx, cy, z, th, dx, dy;
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    th = 0;
    if (ay != 0) begin
      cx = ax <<< CORDIC_PRESHIFT;
      cy = ay <<< CORDIC_PRESHIFT;
      z = 0;
      for (int i = 0; i < CORDIC_ITER; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy > 0) begin
          cx += dx; cy -= dy; z += atan_tab[i];
        end else begin
          cx -= dx; cy += dy; z -= atan_tab[i];
        end
      end
      th = z < 0 ? 0 : z;
    end
    if (x < 0) th = 64'd3373259426 - th;
    return th;
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint gap(longint p, longint lo, longint hi);
    if (p < lo) return lo - p;
    if (p > hi) return p - hi;
    return 0;
  endfunction

  function automatic longint speed_for(longint x, longint y);
    longint dx, dy, span_len, num, den, delta, mag, q;
    dx = gap(x, p_min_x, p_max_x);
    dy = gap(y, p_min_y, p_max_y);
    span_len = root_floor(dx * dx + dy * dy);
    num = span_len - p_near;
    den = p_far - p_near;
    delta = p_vmax - p_vmin;
    if (den == 0) return (num >= 0) ? p_vmax : p_vmin;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (num <= 0) return p_vmin;
    if (num >= den) return p_vmax;
    mag = delta < 0 ? -delta : delta;
    q = (mag * num + den / 2) / den;
    return p_vmin + (delta < 0 ? -q : q);
  endfunction

  function automatic verdict_t limit_step(item_t it);
    verdict_t r;
    longint x, y, v, s;
    r.cons = 1'b0;
    r.rej = 1'b0;
    x = it.x;
    y = it.y;
    case (it.func)
      FUNC_BEGIN: begin
        p_limit = p_vmax;
        p_near = brake_dist(p_vmin);
        p_far = brake_dist(p_vmax);
      end
      FUNC_OBST: begin
        if (it.dyn && !it.clr && bearing_q30(x, y) <= (p_half <<< (ANG_FRAC - FRAC_BITS)))
            begin
          s = speed_for(x, y);
          r.cons = 1'b1;
          if (s < p_limit) p_limit = s;
        end
      end
      FUNC_SCORE: begin
        v = it.vel;
        if (v < 0) v = -v;
        r.rej = v > p_limit;
      end
      default: ;
    endcase
    r.limit = p_limit[15:0];
    return r;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else begin
      if (in_valid && in_ready) awaited.push_back(limit_step(cur));
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 0;
        end else if (!quiet && $urandom_range(0, 19) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_valid <= 0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          func <= cur.func;
          obs_x <= cur.x;
          obs_y <= cur.y;
          is_dynamic <= cur.dyn;
          is_cleared <= cur.clr;
          traj_velocity <= cur.vel;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    verdict_t e;
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited.size() == 0) begin
          $error("result word with no expectation pending");
          fails++;
        end else begin
          e = awaited.pop_front();
          if (speed_limit_out !== e.limit) begin
            $error("speed_limit_out expected %0d actual %0d", e.limit, speed_limit_out);
            fails++;
          end
          if (considered !== e.cons) begin
            $error("considered expected %0d actual %0d", e.cons, considered);
            fails++;
          end
          if (reject !== e.rej) begin
            $error("reject expected %0d actual %0d", e.rej, reject);
            fails++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_ready <= 0;
      end else begin
        out_ready <= 1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      stalled = 0;
    else
      stalled++;
    if (stalled >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDXW-1:0] idx, logic [CFG_DW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      CFG_BOX_MIN_X: p_min_x = $signed(data);
      CFG_BOX_MAX_X: p_max_x = $signed(data);
      CFG_BOX_MIN_Y: p_min_y = $signed(data);
      CFG_BOX_MAX_Y: p_max_y = $signed(data);
      CFG_MIN_SPEED: p_vmin = data[15:0];
      CFG_MAX_SPEED: p_vmax = data[15:0];
      CFG_DECEL:     p_decel = data[15:0];
      CFG_HALF_ANG:  p_half = data[13:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] mnx, logic [23:0] mxx, logic [23:0] mny,
                           logic [23:0] mxy, logic [15:0] vmin, logic [15:0] vmax,
                           logic [15:0] dec, logic [13:0] half);
    write_reg(CFG_BOX_MIN_X, mnx);
    write_reg(CFG_BOX_MAX_X, mxx);
    write_reg(CFG_BOX_MIN_Y, mny);
    write_reg(CFG_BOX_MAX_Y, mxy);
    write_reg(CFG_MIN_SPEED, {8'd0, vmin});
    write_reg(CFG_MAX_SPEED, {8'd0, vmax});
    write_reg(CFG_DECEL, {8'd0, dec});
    write_reg(CFG_HALF_ANG, {10'd0, half});
  endtask

  task automatic add(logic [1:0] f, int x, int y, int dyn, int clr, int vel);
    item_t it;
    it.func = f;
    it.x = 24'(x);
    it.y = 24'(y);
    it.dyn = dyn[0];
    it.clr = clr[0];
    it.vel = 17'(vel);
    pending.push_back(it);
  endtask

  function automatic int coord();
    case ($urandom_range(0, 9))
      0, 1: return $signed($urandom_range(0, 24'hFFFFFF) << 8) >>> 8;
      2: return 0;
      3: return $signed($urandom_range(0, 4095)) - 2048;
      default: return $signed($urandom_range(0, 65535)) - 32768;
    endcase
  endfunction

  task automatic add_obst();
    add(FUNC_OBST, coord(), coord(), int'($urandom_range(0, 9) != 0),
        int'($urandom_range(0, 7) == 0), $urandom);
  endtask

  task automatic add_score();
    int v;
    v = $urandom_range(0, 1) ? $signed($urandom_range(0, 8191)) - 4096
                            : $signed($urandom << 15) >>> 15;
    add(FUNC_SCORE, $urandom, $urandom, $urandom, $urandom, v);
  endtask

  task automatic drain();
    while (pending.size() > 0 || in_valid || awaited.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n;
    p_min_x = -2867; p_max_x = 2867; p_min_y = -2867; p_max_y = 2867;
    p_vmin = 0; p_vmax = 4096; p_decel = 2867; p_half = 6554;
    p_limit = 4096; p_near = 0; p_far = 2926;
    repeat (3) @(posedge clk);
    rst <= 0;

    // Directed words with the reset configuration.
    add(FUNC_SCORE, 0, 0, 0, 0, 4096);
    add(FUNC_SCORE, 0, 0, 0, 0, 4097);
    add(FUNC_OBST, 1000, 0, 1, 0, 0);
    add(FUNC_OBST, 5000, 0, 1, 0, 0);
    add(FUNC_BEGIN, 0, 0, 0, 0, 0);
    add(FUNC_OBST, 40000, 0, 1, 0, 0);
    add(FUNC_OBST, 4500, 100, 1, 0, 0);
    add(FUNC_OBST, -40000, 0, 1, 0, 0);
    add(FUNC_OBST, 3000, 3000, 1, 0, 0);
    add(FUNC_OBST, 3000, -1500, 1, 0, 0);
    add(FUNC_OBST, 3500, 0, 0, 0, 0);
    add(FUNC_OBST, 3500, 0, 1, 1, 0);
    add(FUNC_OBST, 8388607, -8388608, 1, 0, 0);
    add(FUNC_OBST, -8388608, 8388607, 1, 0, 0);
    add(FUNC_OBST, 8388607, 0, 1, 0, 0);
    add(FUNC_OBST, 0, 0, 1, 0, 0);
    add(FUNC_SCORE, 0, 0, 0, 0, 65535);
    add(FUNC_SCORE, 0, 0, 0, 0, -65535);
    add(FUNC_SCORE, 0, 0, 0, 0, -65536);
    add(FUNC_SCORE, 0, 0, 0, 0, 0);
    add(FUNC_UNUSED, -1, -1, 1, 1, -1);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_all(-24'sd2867, 24'sd2867, -24'sd2867, 24'sd2867,
                     16'd0, 16'd4096, 16'd2867, 14'd6554);
        1: write_all(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                     16'd0, 16'd65535, 16'd1, 14'd12868);
        2: write_all(24'h7FFFFF, 24'h800000, 24'sd4000, -24'sd4000,
                     16'd65535, 16'd0, 16'd65535, 14'd0);
        3: write_all(-24'sd1000, 24'sd1000, -24'sd1000, 24'sd1000,
                     16'd2000, 16'd2000, 16'd0, 14'd12868);
        4: write_all(-24'sd8192, 24'sd4096, -24'sd2048, 24'sd2048,
                     16'd6000, 16'd1000, 16'd300, 14'd9000);
        default: write_all(24'(-$urandom_range(0, 16384)), 24'($urandom_range(0, 16384)),
                           24'(-$urandom_range(0, 16384)), 24'($urandom_range(0, 16384)),
                           16'($urandom_range(0, 4096)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(1, 65535)), 14'($urandom_range(0, 12868)));
      endcase
      quiet = (ph >= 7);
      n = 0;
      while (n < 150) begin
        if ($urandom_range(0, 9) != 0) begin
          add(FUNC_BEGIN, $urandom, $urandom, $urandom, $urandom, $urandom);
          n++;
        end
        repeat ($urandom_range(1, 12)) begin
          add_obst();
          n++;
        end
        repeat ($urandom_range(1, 3)) begin
          add_score();
          n++;
        end
        if ($urandom_range(0, 15) == 0) add(FUNC_UNUSED, $urandom, $urandom, $urandom,
                                             $urandom, $urandom);
      end
      drain();
    end

    if (fails == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
